FILE: rtl/fbfl_pkg.sv
// fbfl_pkg: shared types, constants and helpers of the fixed block free list allocator
// no dependencies; imported by fbfl_ring, fbfl_ctrl and the top level

package fbfl_pkg;

    // pool geometry
    localparam int unsigned POOL_BLOCKS = 256;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam longint unsigned POOL_BASE = 4096;

    // widths
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 32;
    localparam int ERR_W  = 32;
    localparam int IDX_W  = $clog2(POOL_BLOCKS);
    localparam int CNT_W  = $clog2(POOL_BLOCKS + 1);
    localparam int STAT_W = 3;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NULL      = 3'd4
    } t_status;

    // request kinds
    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    // ring access from the controller
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [ADDR_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
    } t_ring_req;

    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(POOL_BLOCKS - 1);
    localparam logic [CNT_W-1:0]  POOL_CNT   = CNT_W'(POOL_BLOCKS);
    localparam logic [ADDR_W-1:0] BASE_ADDR  = ADDR_W'(POOL_BASE);
    localparam logic [ADDR_W-1:0] BLOCK_SPAN = ADDR_W'(BLOCK_BYTES);
    localparam logic [SIZE_W-1:0] MAX_SIZE   = SIZE_W'(BLOCK_BYTES);

    // address a slot holds until its first write after reset
    function automatic logic [ADDR_W-1:0] init_addr(input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] offs;
        offs = ADDR_W'(idx) * BLOCK_SPAN;
        return BASE_ADDR + offs;
    endfunction

    // circular index advance
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        nxt = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
        return nxt;
    endfunction

endpackage

FILE: rtl/fbfl_ring.sv
// fbfl_ring: single-port-write, single-port-read ring storage of free block addresses
// depends on fbfl_pkg for widths and the access struct

module fbfl_ring (
    input  logic                         i_clk,
    input  fbfl_pkg::t_ring_req          i_req,
    output logic [fbfl_pkg::ADDR_W-1:0]  o_rd_data
);
    import fbfl_pkg::*;

    logic [ADDR_W-1:0] r_mem [POOL_BLOCKS];
    logic [ADDR_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/fbfl_ctrl.sv
// fbfl_ctrl: request decode, queue pointers, counters and the result register
// depends on fbfl_pkg; drives the ring in fbfl_ring and takes its read data

module fbfl_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_kind,
    input  logic [fbfl_pkg::SIZE_W-1:0]  i_request_size,
    input  logic [fbfl_pkg::ADDR_W-1:0]  i_free_address,
    output fbfl_pkg::t_ring_req          o_ring_req,
    input  logic [fbfl_pkg::ADDR_W-1:0]  i_ring_data,
    output logic                         o_done,
    output logic [fbfl_pkg::STAT_W-1:0]  o_status,
    output logic [fbfl_pkg::ADDR_W-1:0]  o_block_address,
    output logic [fbfl_pkg::ERR_W-1:0]   o_error_total,
    output logic [fbfl_pkg::CNT_W-1:0]   o_outstanding_blocks
);
    import fbfl_pkg::*;

    // queue state
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_qlen, n_qlen;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [ERR_W-1:0]  r_fail, n_fail;

    // result stage
    logic              r_done;
    t_status           r_status, n_status;
    logic              r_pop, n_pop;
    logic              r_stored, n_stored;
    logic [ADDR_W-1:0] r_init;
    logic [CNT_W-1:0]  r_out;

    logic              push;

    // decode the transaction against the current queue state
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_qlen   = r_qlen;
        n_fill   = r_fill;
        n_fail   = r_fail;
        n_status = ST_OK;
        n_pop    = 1'b0;
        push     = 1'b0;
        // slot was written since reset when it lies below the fill mark
        n_stored = (CNT_W'(r_head) < r_fill);
        if (i_kind == KIND_ALLOC) begin
            priority if (i_request_size > MAX_SIZE) begin
                n_status = ST_TOO_LARGE;
                n_fail   = r_fail + ERR_W'(1);
            end else if (r_qlen == '0) begin
                n_status = ST_EMPTY;
                n_fail   = r_fail + ERR_W'(1);
            end else begin
                n_pop  = 1'b1;
                n_head = next_idx(r_head);
                n_qlen = r_qlen - CNT_W'(1);
            end
        end else begin
            priority if (r_qlen >= POOL_CNT) begin
                n_status = ST_FULL;
            end else if (i_free_address == '0) begin
                n_status = ST_NULL;
            end else begin
                push   = 1'b1;
                n_tail = next_idx(r_tail);
                n_qlen = r_qlen + CNT_W'(1);
                if (r_fill < POOL_CNT) begin
                    n_fill = r_fill + CNT_W'(1);
                end
            end
        end
    end

    // ring access: pop reads the head, push writes the tail
    always_comb begin
        o_ring_req.wr_en   = i_accept && push;
        o_ring_req.wr_idx  = r_tail;
        o_ring_req.wr_data = i_free_address;
        o_ring_req.rd_en   = i_accept && n_pop;
        o_ring_req.rd_idx  = r_head;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_qlen <= POOL_CNT;
            r_fill <= '0;
            r_fail <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_accept;
            if (i_accept) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_qlen <= n_qlen;
                r_fill <= n_fill;
                r_fail <= n_fail;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status <= n_status;
            r_pop    <= n_pop;
            r_stored <= n_stored;
            r_init   <= init_addr(r_head);
            r_out    <= POOL_CNT - n_qlen;
        end
    end

    assign o_done               = r_done;
    assign o_status             = r_status;
    assign o_error_total        = r_fail;
    assign o_outstanding_blocks = r_out;

    // popped address comes from the ring or from the slot's reset value
    always_comb begin
        o_block_address = '0;
        if (r_pop) begin
            o_block_address = r_stored ? i_ring_data : r_init;
        end
    end

endmodule

FILE: rtl/fixed_block_free_list_allocator.sv
// fixed_block_free_list_allocator: top level of the fixed-size block pool allocator
// depends on fbfl_pkg, fbfl_ring and fbfl_ctrl

// A transaction is taken at each clock edge with start high and busy low; busy is
// high only while reset is held, so one request is accepted every cycle. Each
// request gives exactly one result, shown on the o_ ports for a single cycle with
// o_done high, in the cycle after acceptance, since the ring read of the head slot
// is registered. Results cannot be stalled, so the receiver must take every result in
// the cycle it appears. No clearing pass runs after reset: slots not yet written
// return their reset address.

module fixed_block_free_list_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_kind,
    input  logic [fbfl_pkg::SIZE_W-1:0]  i_request_size,
    input  logic [fbfl_pkg::ADDR_W-1:0]  i_free_address,
    output logic                         o_done,
    output logic [fbfl_pkg::STAT_W-1:0]  o_status,
    output logic [fbfl_pkg::ADDR_W-1:0]  o_block_address,
    output logic [fbfl_pkg::ERR_W-1:0]   o_error_total,
    output logic [fbfl_pkg::CNT_W-1:0]   o_outstanding_blocks
);
    import fbfl_pkg::*;

    t_ring_req         ring_req;
    logic [ADDR_W-1:0] ring_data;
    logic              accept;

    // request handshake
    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    // free address storage
    fbfl_ring u_ring (
        .i_clk     (i_clk),
        .i_req     (ring_req),
        .o_rd_data (ring_data)
    );

    // queue control and result stage
    fbfl_ctrl u_ctrl (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (accept),
        .i_kind               (i_kind),
        .i_request_size       (i_request_size),
        .i_free_address       (i_free_address),
        .o_ring_req           (ring_req),
        .i_ring_data          (ring_data),
        .o_done               (o_done),
        .o_status             (o_status),
        .o_block_address      (o_block_address),
        .o_error_total        (o_error_total),
        .o_outstanding_blocks (o_outstanding_blocks)
    );

endmodule

FILE: verif/fbfl_checker.sv
// fbfl_checker: tracks the free queue of the block pool allocator and checks every result
// depends on fbfl_pkg; instantiated next to the block by fixed_block_free_list_allocator_tb
`timescale 1ns / 100ps

module fbfl_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        i_kind,
    input  logic [fbfl_pkg::SIZE_W-1:0] i_request_size,
    input  logic [fbfl_pkg::ADDR_W-1:0] i_free_address,
    input  logic                        o_done,
    input  logic [fbfl_pkg::STAT_W-1:0] o_status,
    input  logic [fbfl_pkg::ADDR_W-1:0] o_block_address,
    input  logic [fbfl_pkg::ERR_W-1:0]  o_error_total,
    input  logic [fbfl_pkg::CNT_W-1:0]  o_outstanding_blocks,
    output int                          o_mismatches,
    output int                          o_pending
);
    import fbfl_pkg::*;

    // one expected allocator response
    typedef struct {
        t_status           status;
        logic [ADDR_W-1:0] block_address;
        logic [ERR_W-1:0]  error_total;
        logic [CNT_W-1:0]  outstanding;
    } t_pool_response;

    // shadow copy of the free queue and counters
    logic [ADDR_W-1:0] shadow_ring [POOL_BLOCKS];
    logic [IDX_W-1:0]  shadow_head;
    logic [IDX_W-1:0]  shadow_tail;
    logic [CNT_W-1:0]  shadow_free_cnt;
    logic [ERR_W-1:0]  shadow_failed;

    t_pool_response awaited_responses[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        o_mismatches++;
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // queue full of the pool addresses in order, failure count cleared
    task automatic refill_pool();
        for (int i = 0; i < POOL_BLOCKS; i++) begin
            shadow_ring[i] = ADDR_W'(POOL_BASE + longint'(i) * longint'(BLOCK_BYTES));
        end
        shadow_head     = '0;
        shadow_tail     = '0;
        shadow_free_cnt = CNT_W'(POOL_BLOCKS);
        shadow_failed   = '0;
    endtask

    function automatic logic [IDX_W-1:0] ring_advance(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(POOL_BLOCKS - 1)) ? '0 : idx + 1'b1;
    endfunction

    // pop or push on the shadow queue and build the response
    function automatic t_pool_response apply_request(input t_kind kind,
                                                     input logic [SIZE_W-1:0] size,
                                                     input logic [ADDR_W-1:0] addr);
        t_pool_response resp;
        resp.status        = ST_OK;
        resp.block_address = '0;
        if (kind == KIND_ALLOC) begin
            if (size > SIZE_W'(BLOCK_BYTES)) begin
                resp.status   = ST_TOO_LARGE;
                shadow_failed = shadow_failed + 1'b1;
            end else if (shadow_free_cnt == '0) begin
                resp.status   = ST_EMPTY;
                shadow_failed = shadow_failed + 1'b1;
            end else begin
                resp.block_address = shadow_ring[shadow_head];
                shadow_head        = ring_advance(shadow_head);
                shadow_free_cnt    = shadow_free_cnt - 1'b1;
            end
        end else begin
            // full check takes priority over the null check
            if (shadow_free_cnt >= CNT_W'(POOL_BLOCKS)) begin
                resp.status = ST_FULL;
            end else if (addr == '0) begin
                resp.status = ST_NULL;
            end else begin
                shadow_ring[shadow_tail] = addr;
                shadow_tail              = ring_advance(shadow_tail);
                shadow_free_cnt          = shadow_free_cnt + 1'b1;
            end
        end
        resp.error_total = shadow_failed;
        resp.outstanding = CNT_W'(POOL_BLOCKS) - shadow_free_cnt;
        return resp;
    endfunction

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_pool_response want;
        if (!i_rst_n) begin
            refill_pool();
            awaited_responses.delete();
        end else begin
            if (start && !busy) begin
                awaited_responses.push_back(
                    apply_request(t_kind'(i_kind), i_request_size, i_free_address));
            end
            if (o_done) begin
                if (awaited_responses.size() == 0) begin
                    report_mismatch("response with no request outstanding",
                                    32'(o_status), 32'(o_block_address));
                end else begin
                    want = awaited_responses.pop_front();
                    compare_field("status", 32'(o_status), 32'(want.status));
                    compare_field("block_address", o_block_address, want.block_address);
                    compare_field("error_total", o_error_total, want.error_total);
                    compare_field("outstanding_blocks", 32'(o_outstanding_blocks),
                                  32'(want.outstanding));
                end
            end
        end
        o_pending <= awaited_responses.size();
    end

endmodule

FILE: verif/fixed_block_free_list_allocator_tb.sv
// fixed_block_free_list_allocator_tb: drives alloc and free requests into the pool allocator
// depends on fbfl_pkg, fixed_block_free_list_allocator and fbfl_checker
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_tb;
    import fbfl_pkg::*;

    localparam int IDLE_LIMIT = 500;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_kind;
    logic [SIZE_W-1:0] i_request_size;
    logic [ADDR_W-1:0] i_free_address;
    logic              o_done;
    logic [STAT_W-1:0] o_status;
    logic [ADDR_W-1:0] o_block_address;
    logic [ERR_W-1:0]  o_error_total;
    logic [CNT_W-1:0]  o_outstanding_blocks;
    int                mismatches;
    int                pending;
    int                idle_cycles;

    fixed_block_free_list_allocator DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_kind               (i_kind),
        .i_request_size       (i_request_size),
        .i_free_address       (i_free_address),
        .o_done               (o_done),
        .o_status             (o_status),
        .o_block_address      (o_block_address),
        .o_error_total        (o_error_total),
        .o_outstanding_blocks (o_outstanding_blocks)
    );

    fbfl_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_kind               (i_kind),
        .i_request_size       (i_request_size),
        .i_free_address       (i_free_address),
        .o_done               (o_done),
        .o_status             (o_status),
        .o_block_address      (o_block_address),
        .o_error_total        (o_error_total),
        .o_outstanding_blocks (o_outstanding_blocks),
        .o_mismatches         (mismatches),
        .o_pending            (pending)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog on cycles with no transaction on either side
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return SIZE_W'($urandom_range(0, BLOCK_BYTES));
        end else if (r < 75) begin
            return SIZE_W'(BLOCK_BYTES);
        end else if (r < 80) begin
            return '0;
        end else if (r < 90) begin
            return SIZE_W'($urandom_range(BLOCK_BYTES + 1, 4 * BLOCK_BYTES));
        end
        return $urandom();
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 15) begin
            return '1;
        end else if (r < 55) begin
            return ADDR_W'(POOL_BASE +
                           longint'($urandom_range(0, POOL_BLOCKS - 1)) * BLOCK_BYTES);
        end
        return $urandom();
    endfunction

    // one transaction, then a gap with random noise on the fields
    task automatic issue_request(input t_kind kind, input logic [SIZE_W-1:0] size,
                                 input logic [ADDR_W-1:0] addr, input int gap);
        @(negedge i_clk);
        start          <= 1'b1;
        i_kind         <= kind;
        i_request_size <= size;
        i_free_address <= addr;
        do begin
            @(posedge i_clk);
        end while (busy);
        if (gap > 0) begin
            @(negedge i_clk);
            start          <= 1'b0;
            i_kind         <= 1'($urandom());
            i_request_size <= $urandom();
            i_free_address <= $urandom();
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int count, input int alloc_pct, input bit burst);
        t_kind kind;
        for (int n = 0; n < count; n++) begin
            kind = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
            issue_request(kind, pick_size(), pick_address(), pick_gap(burst));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_kind         = KIND_ALLOC;
        i_request_size = '0;
        i_free_address = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // frees into a full queue, null included, must report full
        issue_request(KIND_FREE, '0, 32'h0000_1234, 0);
        issue_request(KIND_FREE, '1, '0, 0);
        issue_request(KIND_FREE, '0, '1, 2);
        // size limits
        issue_request(KIND_ALLOC, '0, '1, 0);
        issue_request(KIND_ALLOC, SIZE_W'(BLOCK_BYTES), '0, 0);
        issue_request(KIND_ALLOC, SIZE_W'(BLOCK_BYTES + 1), '0, 1);
        issue_request(KIND_ALLOC, '1, '1, 0);
        // null free with room, foreign and duplicate addresses
        issue_request(KIND_FREE, '0, '0, 0);
        issue_request(KIND_FREE, '1, '1, 0);
        issue_request(KIND_FREE, '0, ADDR_W'(POOL_BASE), 3);
        issue_request(KIND_FREE, '0, 32'h8000_0000, 0);
        // foreign address comes back out after the pool addresses
        issue_request(KIND_ALLOC, SIZE_W'(1), '1, 0);
        issue_request(KIND_FREE, '1, 32'h0000_0001, 0);
        issue_request(KIND_ALLOC, '0, '0, 5);
        issue_request(KIND_ALLOC, SIZE_W'(BLOCK_BYTES - 1), '0, 0);
        issue_request(KIND_FREE, '0, 32'hFFFF_FFFE, 0);

        // mixed, drain to empty, refill to full, mixed, alloc-heavy burst
        run_phase(120, 50, 1'b0);
        run_phase(380, 99, 1'b0);
        run_phase(320, 3, 1'b1);
        run_phase(120, 50, 1'b0);
        run_phase(110, 85, 1'b1);

        @(negedge i_clk);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
